FILE: sv/dac_pkg.sv
// shared widths, types and constants of the dihedral angle cosine unit
`timescale 1ns / 1ps
`default_nettype none

package dac_pkg;

	localparam int COORD_BITS    = 20;
	localparam int COS_FRAC_BITS = 14;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int NMAG_W  = 2 * DIFF_W - 1;
	localparam int NRM_W   = NMAG_W + 1;
	localparam int HLO_W   = (NMAG_W + 1) / 2;
	localparam int HHI_W   = NMAG_W - HLO_W;
	localparam int HLL_W   = 2 * HLO_W;
	localparam int HHH_W   = 2 * HHI_W;
	localparam int HMX_W   = HLO_W + HHI_W;
	localparam int MID_W   = HMX_W + 1;
	localparam int SQ_W    = 2 * NMAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int DOT_W   = SUM_W + 1;
	localparam int LIMBS   = 4;
	localparam int LIMB_W  = (SUM_W + LIMBS - 1) / LIMBS;
	localparam int PROD_W  = 2 * SUM_W;
	localparam int REM_W   = PROD_W + 1;
	localparam int QUO_W   = 2 * COS_FRAC_BITS + 3;
	localparam int ROOT_W  = (QUO_W + 1) / 2;
	localparam int COS_W   = COS_FRAC_BITS + 2;
	localparam int COS_ONE = 1 << COS_FRAC_BITS;
	localparam int GEOM_ST = 10;
	localparam int PROD_ST = 5;

	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [NRM_W-1:0]      nrm_t;
	typedef logic [NMAG_W-1:0]            nmag_t;
	typedef logic [HLL_W-1:0]             hll_t;
	typedef logic [HHH_W-1:0]             hhh_t;
	typedef logic [HMX_W-1:0]             hmx_t;
	typedef logic [MID_W-1:0]             mid_t;
	typedef logic [SQ_W-1:0]              sq_t;
	typedef logic [SUM_W-1:0]             sum_t;
	typedef logic signed [DOT_W-1:0]      dot_t;
	typedef logic [LIMBS*LIMB_W-1:0]      lext_t;
	typedef logic [2*LIMB_W-1:0]          pp_t;
	typedef logic [3*LIMB_W:0]            pr_t;
	typedef logic [5*LIMB_W+1:0]          row_t;
	typedef logic [6*LIMB_W+2:0]          hr_t;
	typedef logic [PROD_W-1:0]            prod_t;
	typedef logic [REM_W-1:0]             rem_t;
	typedef logic [QUO_W-1:0]             quo_t;
	typedef logic [ROOT_W-1:0]            root_t;
	typedef logic [2*ROOT_W-1:0]          sqw_t;
	typedef logic signed [COS_W-1:0]      cos_t;

	typedef struct packed {
		logic neg;
		logic degen;
	} tag_t;

endpackage

`default_nettype wire

FILE: sv/dac_if.sv
// word channels: atom quadruple in, cosine result out
`timescale 1ns / 1ps
`default_nettype none

interface dac_in_if;
	logic valid;
	logic ready;
	dac_pkg::coord_t ix, iy, iz, jx, jy, jz, kx, ky, kz, lx, ly, lz;

	modport source (output valid, ix, iy, iz, jx, jy, jz, kx, ky, kz, lx, ly, lz,
		input ready);
	modport sink (input valid, ix, iy, iz, jx, jy, jz, kx, ky, kz, lx, ly, lz,
		output ready);
endinterface

interface dac_out_if;
	logic valid;
	logic ready;
	dac_pkg::cos_t cos_dihedral;
	logic degenerate;

	modport source (output valid, cos_dihedral, degenerate, input ready);
	modport sink (input valid, cos_dihedral, degenerate, output ready);
endinterface

`default_nettype wire

FILE: sv/dac_geom.sv
// normals, squared norms and dot product, ten pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module dac_geom (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   vld_i,
	input  wire dac_pkg::coord_t  pos [4][3],
	output logic                  vld_o,
	output dac_pkg::sum_t         dmag,
	output dac_pkg::sum_t         nsq1,
	output dac_pkg::sum_t         nsq2,
	output dac_pkg::tag_t         tag
);

	logic [dac_pkg::GEOM_ST:1] vld_s;

	dac_pkg::diff_t u1_s1 [3], v1_s1 [3], u2_s1 [3], v2_s1 [3];
	dac_pkg::nrm_t  p1_s2 [3], q1_s2 [3], p2_s2 [3], q2_s2 [3];
	dac_pkg::nrm_t  n1_s3 [3], n2_s3 [3];
	dac_pkg::nmag_t m1_s4 [3], m2_s4 [3];
	logic           g1_s4 [3], g2_s4 [3];
	dac_pkg::nmag_t ma [9], mb [9];
	dac_pkg::hll_t  ll_s5 [9];
	dac_pkg::hhh_t  hh_s5 [9];
	dac_pkg::hmx_t  hl_s5 [9], lh_s5 [9];
	logic           tn_s5 [3], tn_s6 [3], tn_s7 [3];
	dac_pkg::sq_t   lohi_s6 [9];
	dac_pkg::mid_t  mid_s6 [9];
	dac_pkg::sq_t   full_s7 [9];
	dac_pkg::sum_t  ss1_s8, ss2_s8, ss1_s9, ss2_s9, ss1_s10, ss2_s10;
	dac_pkg::dot_t  dt_s8 [3];
	dac_pkg::dot_t  dot_s9;
	logic           dg_s9, dg_s10, neg_s10;
	dac_pkg::sum_t  dmag_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[dac_pkg::GEOM_ST-1:1], vld_i};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ma[k]     = m1_s4[k];
			mb[k]     = m1_s4[k];
			ma[k + 3] = m2_s4[k];
			mb[k + 3] = m2_s4[k];
			ma[k + 6] = m1_s4[k];
			mb[k + 6] = m2_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				u1_s1[k] <= dac_pkg::diff_t'(pos[1][k]) - dac_pkg::diff_t'(pos[0][k]);
				v1_s1[k] <= dac_pkg::diff_t'(pos[2][k]) - dac_pkg::diff_t'(pos[0][k]);
				u2_s1[k] <= dac_pkg::diff_t'(pos[0][k]) - dac_pkg::diff_t'(pos[1][k]);
				v2_s1[k] <= dac_pkg::diff_t'(pos[3][k]) - dac_pkg::diff_t'(pos[1][k]);

				p1_s2[k] <= dac_pkg::nrm_t'(u1_s1[dac_pkg::NXT1[k]])
					* dac_pkg::nrm_t'(v1_s1[dac_pkg::NXT2[k]]);
				q1_s2[k] <= dac_pkg::nrm_t'(u1_s1[dac_pkg::NXT2[k]])
					* dac_pkg::nrm_t'(v1_s1[dac_pkg::NXT1[k]]);
				p2_s2[k] <= dac_pkg::nrm_t'(u2_s1[dac_pkg::NXT1[k]])
					* dac_pkg::nrm_t'(v2_s1[dac_pkg::NXT2[k]]);
				q2_s2[k] <= dac_pkg::nrm_t'(u2_s1[dac_pkg::NXT2[k]])
					* dac_pkg::nrm_t'(v2_s1[dac_pkg::NXT1[k]]);

				n1_s3[k] <= p1_s2[k] - q1_s2[k];
				n2_s3[k] <= p2_s2[k] - q2_s2[k];

				m1_s4[k] <= dac_pkg::nmag_t'(n1_s3[k][dac_pkg::NRM_W-1] ? -n1_s3[k] : n1_s3[k]);
				m2_s4[k] <= dac_pkg::nmag_t'(n2_s3[k][dac_pkg::NRM_W-1] ? -n2_s3[k] : n2_s3[k]);
				g1_s4[k] <= n1_s3[k][dac_pkg::NRM_W-1];
				g2_s4[k] <= n2_s3[k][dac_pkg::NRM_W-1];

				tn_s5[k] <= g1_s4[k] ^ g2_s4[k];
				tn_s6[k] <= tn_s5[k];
				tn_s7[k] <= tn_s6[k];
			end

			for (int m = 0; m < 9; m++) begin
				ll_s5[m] <= dac_pkg::hll_t'(ma[m][dac_pkg::HLO_W-1:0])
					* dac_pkg::hll_t'(mb[m][dac_pkg::HLO_W-1:0]);
				hh_s5[m] <= dac_pkg::hhh_t'(ma[m][dac_pkg::NMAG_W-1:dac_pkg::HLO_W])
					* dac_pkg::hhh_t'(mb[m][dac_pkg::NMAG_W-1:dac_pkg::HLO_W]);
				hl_s5[m] <= dac_pkg::hmx_t'(ma[m][dac_pkg::NMAG_W-1:dac_pkg::HLO_W])
					* dac_pkg::hmx_t'(mb[m][dac_pkg::HLO_W-1:0]);
				lh_s5[m] <= dac_pkg::hmx_t'(ma[m][dac_pkg::HLO_W-1:0])
					* dac_pkg::hmx_t'(mb[m][dac_pkg::NMAG_W-1:dac_pkg::HLO_W]);

				lohi_s6[m] <= {hh_s5[m], ll_s5[m]};
				mid_s6[m]  <= dac_pkg::mid_t'(hl_s5[m]) + dac_pkg::mid_t'(lh_s5[m]);

				full_s7[m] <= lohi_s6[m] + (dac_pkg::sq_t'(mid_s6[m]) << dac_pkg::HLO_W);
			end

			ss1_s8 <= dac_pkg::sum_t'(full_s7[0]) + dac_pkg::sum_t'(full_s7[1])
				+ dac_pkg::sum_t'(full_s7[2]);
			ss2_s8 <= dac_pkg::sum_t'(full_s7[3]) + dac_pkg::sum_t'(full_s7[4])
				+ dac_pkg::sum_t'(full_s7[5]);
			for (int k = 0; k < 3; k++) begin
				dt_s8[k] <= tn_s7[k] ? -dac_pkg::dot_t'(full_s7[k + 6])
					: dac_pkg::dot_t'(full_s7[k + 6]);
			end

			dot_s9 <= dt_s8[0] + dt_s8[1] + dt_s8[2];
			ss1_s9 <= ss1_s8;
			ss2_s9 <= ss2_s8;
			dg_s9  <= (ss1_s8 == '0) || (ss2_s8 == '0);

			dmag_s10 <= dac_pkg::sum_t'(dot_s9[dac_pkg::DOT_W-1] ? -dot_s9 : dot_s9);
			neg_s10  <= dot_s9[dac_pkg::DOT_W-1];
			ss1_s10  <= ss1_s9;
			ss2_s10  <= ss2_s9;
			dg_s10   <= dg_s9;
		end
	end

	assign vld_o     = vld_s[dac_pkg::GEOM_ST];
	assign dmag      = dmag_s10;
	assign nsq1      = ss1_s10;
	assign nsq2      = ss2_s10;
	assign tag.neg   = neg_s10;
	assign tag.degen = dg_s10;

endmodule

`default_nettype wire

FILE: sv/dac_prod.sv
// squared dot and product of squared norms, limb multipliers over five stages
`timescale 1ns / 1ps
`default_nettype none

module dac_prod (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  vld_i,
	input  wire dac_pkg::sum_t   dmag,
	input  wire dac_pkg::sum_t   nsq1,
	input  wire dac_pkg::sum_t   nsq2,
	input  wire dac_pkg::tag_t   tag_i,
	output logic                 vld_o,
	output dac_pkg::prod_t       dsq,
	output dac_pkg::prod_t       pnorm,
	output dac_pkg::tag_t        tag_o
);

	logic [dac_pkg::PROD_ST:1] vld_s;
	dac_pkg::tag_t  tg_s [1:dac_pkg::PROD_ST];
	dac_pkg::lext_t opa [2], opb [2];
	dac_pkg::pp_t   pp_s1 [2][dac_pkg::LIMBS][dac_pkg::LIMBS];
	dac_pkg::pr_t   pr_s2 [2][dac_pkg::LIMBS][2];
	dac_pkg::row_t  row_s3 [2][dac_pkg::LIMBS];
	dac_pkg::hr_t   hr_s4 [2][2];
	dac_pkg::prod_t fp_s5 [2];

	assign opa[0] = dac_pkg::lext_t'(dmag);
	assign opb[0] = dac_pkg::lext_t'(dmag);
	assign opa[1] = dac_pkg::lext_t'(nsq1);
	assign opb[1] = dac_pkg::lext_t'(nsq2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[dac_pkg::PROD_ST-1:1], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tg_s[1] <= tag_i;
			for (int s = 2; s <= dac_pkg::PROD_ST; s++) begin
				tg_s[s] <= tg_s[s - 1];
			end
			for (int x = 0; x < 2; x++) begin
				for (int i = 0; i < dac_pkg::LIMBS; i++) begin
					for (int j = 0; j < dac_pkg::LIMBS; j++) begin
						pp_s1[x][i][j] <=
							dac_pkg::pp_t'(opa[x][i*dac_pkg::LIMB_W +: dac_pkg::LIMB_W])
							* dac_pkg::pp_t'(opb[x][j*dac_pkg::LIMB_W +: dac_pkg::LIMB_W]);
					end
					for (int h = 0; h < 2; h++) begin
						pr_s2[x][i][h] <= dac_pkg::pr_t'(pp_s1[x][i][2*h])
							+ (dac_pkg::pr_t'(pp_s1[x][i][2*h+1]) << dac_pkg::LIMB_W);
					end
					row_s3[x][i] <= dac_pkg::row_t'(pr_s2[x][i][0])
						+ (dac_pkg::row_t'(pr_s2[x][i][1]) << (2 * dac_pkg::LIMB_W));
				end
				for (int g = 0; g < 2; g++) begin
					hr_s4[x][g] <= dac_pkg::hr_t'(row_s3[x][2*g])
						+ (dac_pkg::hr_t'(row_s3[x][2*g+1]) << dac_pkg::LIMB_W);
				end
				fp_s5[x] <= dac_pkg::prod_t'(hr_s4[x][0])
					+ (dac_pkg::prod_t'(hr_s4[x][1]) << (2 * dac_pkg::LIMB_W));
			end
		end
	end

	assign vld_o = vld_s[dac_pkg::PROD_ST];
	assign dsq   = fp_s5[0];
	assign pnorm = fp_s5[1];
	assign tag_o = tg_s[dac_pkg::PROD_ST];

endmodule

`default_nettype wire

FILE: sv/dac_div.sv
// restoring divider, one quotient bit per stage: floor(dsq * 4^(F+1) / pnorm)
`timescale 1ns / 1ps
`default_nettype none

module dac_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  vld_i,
	input  wire dac_pkg::prod_t  dsq,
	input  wire dac_pkg::prod_t  pnorm,
	input  wire dac_pkg::tag_t   tag_i,
	output logic                 vld_o,
	output dac_pkg::quo_t        quo,
	output dac_pkg::tag_t        tag_o
);

	localparam int N = dac_pkg::QUO_W;

	dac_pkg::rem_t  rem_s [N-1];
	dac_pkg::prod_t pn_s [N-1];
	dac_pkg::quo_t  q_s [N];
	dac_pkg::tag_t  tg_s [N];
	logic           vld_s [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		dac_pkg::rem_t  r_in;
		dac_pkg::prod_t pn;
		dac_pkg::quo_t  q_prev;
		dac_pkg::tag_t  t_prev;
		logic           v_prev;
		logic           ge;

		if (k == 0) begin : g_head
			assign r_in   = dac_pkg::rem_t'(dsq);
			assign pn     = pnorm;
			assign q_prev = '0;
			assign t_prev = tag_i;
			assign v_prev = vld_i;
		end else begin : g_body
			assign r_in   = rem_s[k-1] << 1;
			assign pn     = pn_s[k-1];
			assign q_prev = q_s[k-1];
			assign t_prev = tg_s[k-1];
			assign v_prev = vld_s[k-1];
		end

		assign ge = r_in >= dac_pkg::rem_t'(pn);

		if (k < N - 1) begin : g_rem
			dac_pkg::rem_t diff;
			assign diff = r_in - dac_pkg::rem_t'(pn);
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff : r_in;
					pn_s[k]  <= pn;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]  <= q_prev | (dac_pkg::quo_t'(ge) << (N - 1 - k));
				tg_s[k] <= t_prev;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_prev;
			end
		end
	end

	assign vld_o = vld_s[N-1];
	assign quo   = q_s[N-1];
	assign tag_o = tg_s[N-1];

endmodule

`default_nettype wire

FILE: sv/dac_sqrt.sv
// integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module dac_sqrt (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 vld_i,
	input  wire dac_pkg::quo_t  quo,
	input  wire dac_pkg::tag_t  tag_i,
	output logic                vld_o,
	output dac_pkg::root_t      root,
	output dac_pkg::tag_t       tag_o
);

	localparam int N = dac_pkg::ROOT_W;

	dac_pkg::quo_t  x_s [N-1];
	dac_pkg::root_t r_s [N];
	dac_pkg::tag_t  tg_s [N];
	logic           vld_s [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		dac_pkg::root_t r_prev;
		dac_pkg::quo_t  x_prev;
		dac_pkg::tag_t  t_prev;
		logic           v_prev;
		dac_pkg::root_t trial;
		dac_pkg::sqw_t  tsq;
		logic           fit;

		if (k == 0) begin : g_head
			assign r_prev = '0;
			assign x_prev = quo;
			assign t_prev = tag_i;
			assign v_prev = vld_i;
		end else begin : g_body
			assign r_prev = r_s[k-1];
			assign x_prev = x_s[k-1];
			assign t_prev = tg_s[k-1];
			assign v_prev = vld_s[k-1];
		end

		assign trial = r_prev | (dac_pkg::root_t'(1) << (N - 1 - k));
		assign tsq   = dac_pkg::sqw_t'(trial) * dac_pkg::sqw_t'(trial);
		assign fit   = tsq <= dac_pkg::sqw_t'(x_prev);

		if (k < N - 1) begin : g_x
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k] <= x_prev;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]  <= fit ? trial : r_prev;
				tg_s[k] <= t_prev;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_prev;
			end
		end
	end

	assign vld_o = vld_s[N-1];
	assign root  = r_s[N-1];
	assign tag_o = tg_s[N-1];

endmodule

`default_nettype wire

FILE: sv/dihedral_angle_cosine_unit.sv
// top level of the dihedral angle cosine unit
// usage:
//   item channel takes one word per cycle while item ready is high: the
//   positions of atoms i, j, k, l as signed fixed point. result channel
//   returns one word per item: the cosine of the dihedral angle in signed
//   Q1.14 and a degenerate flag that is set, with a zero cosine, when
//   either plane normal is zero. an accepted item passes the normals and
//   dot product, the wide limb products, the bit-per-stage divider, the
//   bit-per-stage square root, then rounding and sign, before result valid.
//   throughput is one word per cycle while the receiver does not stall;
//   the whole pipeline moves on one enable, so results leave in order.
//   reset clears every valid bit; no result is shown until an item has
//   passed the full pipeline.
//   when the receiver holds ready low with a result waiting, the pipeline
//   freezes and item ready drops in the same cycle; bubbles still move
//   while the output register is empty.
`timescale 1ns / 1ps
`default_nettype none

module dihedral_angle_cosine_unit (
	input  wire        clk,
	input  wire        arst_n,
	dac_in_if.sink     item,
	dac_out_if.source  result
);

	logic            adv;
	dac_pkg::coord_t pos [4][3];

	logic            g_vld, p_vld, d_vld, r_vld;
	dac_pkg::sum_t   g_dmag, g_nsq1, g_nsq2;
	dac_pkg::tag_t   g_tag, p_tag, d_tag, r_tag;
	dac_pkg::prod_t  p_dsq, p_pnorm;
	dac_pkg::quo_t   d_quo;
	dac_pkg::root_t  r_root;

	logic [dac_pkg::ROOT_W:0] rinc;
	dac_pkg::root_t  half;
	dac_pkg::root_t  mag;
	dac_pkg::cos_t   cos_d;

	logic            out_v_q;
	dac_pkg::cos_t   cos_q;
	logic            deg_q;

	assign adv        = !out_v_q || result.ready;
	assign item.ready = adv;

	assign pos[0][0] = item.ix;
	assign pos[0][1] = item.iy;
	assign pos[0][2] = item.iz;
	assign pos[1][0] = item.jx;
	assign pos[1][1] = item.jy;
	assign pos[1][2] = item.jz;
	assign pos[2][0] = item.kx;
	assign pos[2][1] = item.ky;
	assign pos[2][2] = item.kz;
	assign pos[3][0] = item.lx;
	assign pos[3][1] = item.ly;
	assign pos[3][2] = item.lz;

	dac_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (item.valid),
		.pos    (pos),
		.vld_o  (g_vld),
		.dmag   (g_dmag),
		.nsq1   (g_nsq1),
		.nsq2   (g_nsq2),
		.tag    (g_tag)
	);

	dac_prod u_prod (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (g_vld),
		.dmag   (g_dmag),
		.nsq1   (g_nsq1),
		.nsq2   (g_nsq2),
		.tag_i  (g_tag),
		.vld_o  (p_vld),
		.dsq    (p_dsq),
		.pnorm  (p_pnorm),
		.tag_o  (p_tag)
	);

	dac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (p_vld),
		.dsq    (p_dsq),
		.pnorm  (p_pnorm),
		.tag_i  (p_tag),
		.vld_o  (d_vld),
		.quo    (d_quo),
		.tag_o  (d_tag)
	);

	dac_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (d_vld),
		.quo    (d_quo),
		.tag_i  (d_tag),
		.vld_o  (r_vld),
		.root   (r_root),
		.tag_o  (r_tag)
	);

	// largest odd number not above the root gives twice the rounded value minus one
	assign rinc = {1'b0, r_root} + 1'b1;
	assign half = rinc[dac_pkg::ROOT_W:1];
	assign mag  = (half > dac_pkg::root_t'(dac_pkg::COS_ONE))
		? dac_pkg::root_t'(dac_pkg::COS_ONE) : half;

	always_comb begin
		if (r_tag.degen) begin
			cos_d = '0;
		end else if (r_tag.neg) begin
			cos_d = dac_pkg::cos_t'(mag);
		end else begin
			cos_d = -dac_pkg::cos_t'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_q <= cos_d;
			deg_q <= r_tag.degen;
		end
	end

	assign result.valid        = out_v_q;
	assign result.cos_dihedral = cos_q;
	assign result.degenerate   = deg_q;

endmodule

`default_nettype wire

FILE: sv/dac_chk.sv
// port checker for the dihedral angle cosine unit and its bind
`timescale 1ns / 1ps
`default_nettype none

module dac_chk (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire dac_pkg::cos_t  cos,
	input wire                 degen
);

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degen |-> cos == '0)
		else $error("degenerate word with nonzero cosine");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cos >= -dac_pkg::COS_ONE) && (cos <= dac_pkg::COS_ONE))
		else $error("cosine outside plus or minus one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cos) && $stable(degen))
		else $error("stalled result word changed");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output register");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result word");

endmodule

bind dihedral_angle_cosine_unit dac_chk u_dac_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.cos       (result.cos_dihedral),
	.degen     (result.degenerate)
);

`default_nettype wire
